>>> hw/rtl/line_follow_steering_core_assert.svh
// Assertion macros used by the checker file lfs_checker.sv.
`ifndef LINE_FOLLOW_STEERING_CORE_ASSERT_SVH
`define LINE_FOLLOW_STEERING_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LFS_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define LFS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after reset is applied.
`define LFS_ASSERT_RESET(label, cons) \
   label: assert property (@(posedge clock) reset |=> (cons)) \
      else $error("assertion failed");

`endif

>>> hw/rtl/lfs_pkg.sv
`timescale 1ns / 1ps

package lfs_pkg;

   localparam int CSR_IDX_W = 3;
   localparam int CSR_W     = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_MODE        = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_SPEED  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SHARP_GAIN  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SMOOTH_GAIN = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PROP_GAIN   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DERIV_GAIN  = 3'd5;

   typedef enum logic [1:0] {
      MODE_DIG3 = 2'd0,
      MODE_DIG2 = 2'd1,
      MODE_PD   = 2'd2,
      MODE_ONE  = 2'd3
   } mode_type;

   localparam int LEVEL_W = 10;
   localparam int ERR_W   = 11;
   localparam int DIFF_W  = 12;
   localparam int GAIN_W  = 16;
   localparam int PROP_W  = GAIN_W + ERR_W;
   localparam int DER_W   = GAIN_W + DIFF_W;
   localparam int ACC_W   = 28;
   localparam int SPD_W   = ACC_W - 8;
   localparam int OFF_W   = 13;
   localparam int AMT_W   = 12;

   typedef struct packed {
      logic [2:0]         line_bits;
      logic [LEVEL_W-1:0] left_level;
      logic [LEVEL_W-1:0] right_level;
   } req_word_type;

   typedef struct packed {
      logic       left_forward;
      logic [7:0] left_duty;
      logic       right_forward;
      logic [7:0] right_duty;
   } rsp_word_type;

   typedef struct packed {
      mode_type                  mode;
      logic [7:0]                base_speed;
      logic [3:0]                sharp_gain;
      logic [3:0]                smooth_gain;
      logic signed [GAIN_W-1:0]  prop_gain;
      logic signed [GAIN_W-1:0]  deriv_gain;
   } cfg_type;

   typedef struct packed {
      logic                     pd;
      logic signed [OFF_W-1:0]  offset;
      logic signed [ERR_W-1:0]  err;
      logic signed [DIFF_W-1:0] diff;
   } front_word_type;

   typedef struct packed {
      logic                     pd;
      logic signed [OFF_W-1:0]  offset;
      logic signed [PROP_W-1:0] prop_term;
      logic signed [DER_W-1:0]  deriv_term;
   } mult_word_type;

endpackage

>>> hw/rtl/lfs_csr.sv
`timescale 1ns / 1ps

module lfs_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_en,
   input  logic [lfs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lfs_pkg::CSR_W-1:0]     csr_data,
   output lfs_pkg::cfg_type              cfg
);

   lfs_pkg::cfg_type cfg_ff;
   lfs_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            lfs_pkg::CSR_MODE:        cfg_in.mode = lfs_pkg::mode_type'(csr_data[1:0]);
            lfs_pkg::CSR_BASE_SPEED:  cfg_in.base_speed = csr_data[7:0];
            lfs_pkg::CSR_SHARP_GAIN:  cfg_in.sharp_gain = csr_data[3:0];
            lfs_pkg::CSR_SMOOTH_GAIN: cfg_in.smooth_gain = csr_data[3:0];
            lfs_pkg::CSR_PROP_GAIN:   cfg_in.prop_gain = $signed(csr_data);
            lfs_pkg::CSR_DERIV_GAIN:  cfg_in.deriv_gain = $signed(csr_data);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode        <= lfs_pkg::MODE_DIG3;
         cfg_ff.base_speed  <= 8'd120;
         cfg_ff.sharp_gain  <= 4'd1;
         cfg_ff.smooth_gain <= 4'd1;
         cfg_ff.prop_gain   <= '0;
         cfg_ff.deriv_gain  <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> hw/rtl/lfs_front.sv
`timescale 1ns / 1ps

module lfs_front (
   input  logic                    clock,
   input  logic                    reset,
   input  lfs_pkg::cfg_type        cfg,
   input  logic                    in_valid,
   output logic                    in_stall,
   input  lfs_pkg::req_word_type   in_word,
   output logic                    out_valid,
   input  logic                    out_stall,
   output lfs_pkg::front_word_type out_word
);

   localparam logic [2:0] PAT_RIGHT     = 3'b001;
   localparam logic [2:0] PAT_RIGHT_CTR = 3'b011;
   localparam logic [2:0] PAT_LEFT      = 3'b100;
   localparam logic [2:0] PAT_SPLIT     = 3'b101;
   localparam logic [2:0] PAT_LEFT_CTR  = 3'b110;
   localparam logic [1:0] PAT2_RIGHT    = 2'b01;
   localparam logic [1:0] PAT2_LEFT     = 2'b10;

   localparam logic [7:0] SHARP_STEP  = 8'd160;
   localparam logic [7:0] SMOOTH_STEP = 8'd70;
   localparam logic [lfs_pkg::LEVEL_W-1:0] ONE_LOW  = 10'd400;
   localparam logic [lfs_pkg::LEVEL_W-1:0] ONE_HIGH = 10'd800;
   localparam logic signed [lfs_pkg::OFF_W-1:0] ONE_STEER = 13'sd100;

   logic                                  valid_ff;
   logic                                  valid_in;
   lfs_pkg::front_word_type               word_ff;
   lfs_pkg::front_word_type               word_in;
   logic signed [lfs_pkg::ERR_W-1:0]      prev_ff;
   logic signed [lfs_pkg::ERR_W-1:0]      prev_in;
   logic                                  hold;
   logic                                  accept;
   logic                                  emit;
   logic [lfs_pkg::AMT_W-1:0]             sharp_amt;
   logic [lfs_pkg::AMT_W-1:0]             smooth_amt;
   logic signed [lfs_pkg::OFF_W-1:0]      sharp_off;
   logic signed [lfs_pkg::OFF_W-1:0]      smooth_off;

   assign hold     = valid_ff && out_stall;
   assign accept   = in_valid && !hold;
   assign in_stall = hold;

   assign sharp_amt  = lfs_pkg::AMT_W'(cfg.sharp_gain) * lfs_pkg::AMT_W'(SHARP_STEP);
   assign smooth_amt = lfs_pkg::AMT_W'(cfg.smooth_gain) * lfs_pkg::AMT_W'(SMOOTH_STEP);
   assign sharp_off  = $signed({1'b0, sharp_amt});
   assign smooth_off = $signed({1'b0, smooth_amt});

   always_comb begin
      emit           = 1'b1;
      word_in.pd     = 1'b0;
      word_in.offset = '0;
      word_in.err    = $signed({1'b0, in_word.left_level})
                       - $signed({1'b0, in_word.right_level});
      word_in.diff   = lfs_pkg::DIFF_W'(word_in.err) - lfs_pkg::DIFF_W'(prev_ff);
      case (cfg.mode)
         lfs_pkg::MODE_DIG3: begin
            case (in_word.line_bits)
               PAT_RIGHT:     word_in.offset = sharp_off;
               PAT_RIGHT_CTR: word_in.offset = smooth_off;
               PAT_LEFT:      word_in.offset = -sharp_off;
               PAT_LEFT_CTR:  word_in.offset = -smooth_off;
               PAT_SPLIT:     emit = 1'b0;
               default:       word_in.offset = '0;
            endcase
         end
         lfs_pkg::MODE_DIG2: begin
            case (in_word.line_bits[1:0])
               PAT2_RIGHT: word_in.offset = sharp_off;
               PAT2_LEFT:  word_in.offset = -sharp_off;
               default:    word_in.offset = '0;
            endcase
         end
         lfs_pkg::MODE_PD: begin
            word_in.pd = 1'b1;
         end
         default: begin
            if (in_word.left_level == '0) begin
               emit = 1'b0;
            end else if (in_word.left_level <= ONE_LOW) begin
               word_in.offset = -ONE_STEER;
            end else if (in_word.left_level < ONE_HIGH) begin
               word_in.offset = '0;
            end else begin
               word_in.offset = ONE_STEER;
            end
         end
      endcase
   end

   assign valid_in = hold ? valid_ff : (in_valid && emit);
   assign prev_in  = (accept && word_in.pd) ? word_in.err : prev_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         prev_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         prev_ff  <= prev_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

>>> hw/rtl/lfs_mult.sv
`timescale 1ns / 1ps

module lfs_mult (
   input  logic                    clock,
   input  logic                    reset,
   input  lfs_pkg::cfg_type        cfg,
   input  logic                    in_valid,
   output logic                    in_stall,
   input  lfs_pkg::front_word_type in_word,
   output logic                    out_valid,
   input  logic                    out_stall,
   output lfs_pkg::mult_word_type  out_word
);

   logic                   valid_ff;
   logic                   valid_in;
   lfs_pkg::mult_word_type word_ff;
   lfs_pkg::mult_word_type word_in;
   logic                   hold;
   logic                   accept;

   assign hold     = valid_ff && out_stall;
   assign accept   = in_valid && !hold;
   assign in_stall = hold;

   always_comb begin
      word_in.pd         = in_word.pd;
      word_in.offset     = in_word.offset;
      word_in.prop_term  = lfs_pkg::PROP_W'(cfg.prop_gain) * lfs_pkg::PROP_W'(in_word.err);
      word_in.deriv_term = lfs_pkg::DER_W'(cfg.deriv_gain) * lfs_pkg::DER_W'(in_word.diff);
   end

   assign valid_in = hold ? valid_ff : in_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

>>> hw/rtl/lfs_drive.sv
`timescale 1ns / 1ps

module lfs_drive (
   input  logic                   clock,
   input  logic                   reset,
   input  lfs_pkg::cfg_type       cfg,
   input  logic                   in_valid,
   output logic                   in_stall,
   input  lfs_pkg::mult_word_type in_word,
   output logic                   out_valid,
   input  logic                   out_stall,
   output lfs_pkg::rsp_word_type  out_word
);

   typedef struct packed {
      logic       forward;
      logic [7:0] duty;
   } motor_type;

   function automatic logic signed [lfs_pkg::SPD_W-1:0] trunc_div256(
      input logic signed [lfs_pkg::ACC_W-1:0] x
   );
      logic signed [lfs_pkg::ACC_W-1:0] adj;
      adj = x + (x[lfs_pkg::ACC_W-1] ? lfs_pkg::ACC_W'(255) : '0);
      return adj[lfs_pkg::ACC_W-1:8];
   endfunction

   function automatic motor_type motor_drive(input logic signed [lfs_pkg::SPD_W-1:0] speed);
      motor_type                 m;
      logic [lfs_pkg::SPD_W-1:0] mag;
      mag       = speed[lfs_pkg::SPD_W-1] ? -speed : speed;
      m.forward = !speed[lfs_pkg::SPD_W-1] && (speed != '0);
      m.duty    = (mag > lfs_pkg::SPD_W'(255)) ? 8'hFF : mag[7:0];
      return m;
   endfunction

   logic                                valid_ff;
   logic                                valid_in;
   lfs_pkg::rsp_word_type               word_ff;
   lfs_pkg::rsp_word_type               word_in;
   logic                                hold;
   logic                                accept;
   logic signed [lfs_pkg::ACC_W-1:0]    steer;
   logic signed [lfs_pkg::ACC_W-1:0]    base_acc;
   logic signed [lfs_pkg::SPD_W-1:0]    base_spd;
   logic signed [lfs_pkg::SPD_W-1:0]    left_speed;
   logic signed [lfs_pkg::SPD_W-1:0]    right_speed;
   motor_type                           left_motor;
   motor_type                           right_motor;

   assign hold     = valid_ff && out_stall;
   assign accept   = in_valid && !hold;
   assign in_stall = hold;

   assign steer    = lfs_pkg::ACC_W'(in_word.prop_term) + lfs_pkg::ACC_W'(in_word.deriv_term);
   assign base_acc = lfs_pkg::ACC_W'($signed({1'b0, cfg.base_speed, 8'h00}));
   assign base_spd = lfs_pkg::SPD_W'($signed({1'b0, cfg.base_speed}));

   always_comb begin
      if (in_word.pd) begin
         left_speed  = trunc_div256(base_acc + steer);
         right_speed = trunc_div256(base_acc - steer);
      end else begin
         left_speed  = base_spd + lfs_pkg::SPD_W'(in_word.offset);
         right_speed = base_spd - lfs_pkg::SPD_W'(in_word.offset);
      end
      left_motor             = motor_drive(left_speed);
      right_motor            = motor_drive(right_speed);
      word_in.left_forward   = left_motor.forward;
      word_in.left_duty      = left_motor.duty;
      word_in.right_forward  = right_motor.forward;
      word_in.right_duty     = right_motor.duty;
   end

   assign valid_in = hold ? valid_ff : in_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

>>> hw/rtl/line_follow_steering_core.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  req_word (line_bits, left/right level)
// rsp       out        rsp_valid/rsp_stall  rsp_word (direction and duty per motor)
// csr       in         csr_write_en         csr_index, csr_data
//
// One word is accepted per cycle while req_stall is low; each result passes through the
// input register, the register after the two gain multipliers and the output register.
// Reset is synchronous, sets the configuration to its defaults and clears the stored PD error and all valids.
// Each stage holds only while it is full and the next one stalls, so empty stages keep
// taking words while a result waits on rsp_stall.

module line_follow_steering_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  lfs_pkg::req_word_type         req_word,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output lfs_pkg::rsp_word_type         rsp_word,
   input  logic                          csr_write_en,
   input  logic [lfs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lfs_pkg::CSR_W-1:0]     csr_data
);

   lfs_pkg::cfg_type        cfg;
   logic                    front_valid;
   logic                    front_stall;
   lfs_pkg::front_word_type front_word;
   logic                    mult_valid;
   logic                    mult_stall;
   lfs_pkg::mult_word_type  mult_word;

   lfs_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .cfg          (cfg)
   );

   lfs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_word   (req_word),
      .out_valid (front_valid),
      .out_stall (front_stall),
      .out_word  (front_word)
   );

   lfs_mult u_mult (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (front_valid),
      .in_stall  (front_stall),
      .in_word   (front_word),
      .out_valid (mult_valid),
      .out_stall (mult_stall),
      .out_word  (mult_word)
   );

   lfs_drive u_drive (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (mult_valid),
      .in_stall  (mult_stall),
      .in_word   (mult_word),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_word  (rsp_word)
   );

endmodule

>>> hw/rtl/lfs_checker.sv
`timescale 1ns / 1ps
`include "line_follow_steering_core_assert.svh"

module lfs_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input lfs_pkg::rsp_word_type rsp_word
);

   // A forward motor always has a nonzero duty.
   `LFS_ASSERT_IMPL(a_left_fwd_duty, rsp_valid && rsp_word.left_forward, rsp_word.left_duty != 8'd0)
   `LFS_ASSERT_IMPL(a_right_fwd_duty, rsp_valid && rsp_word.right_forward, rsp_word.right_duty != 8'd0)
   `LFS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_word))
   `LFS_ASSERT_RESET(a_rsp_reset, !rsp_valid)

endmodule

bind line_follow_steering_core lfs_checker u_lfs_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);

>>> test/line_follow_steering_checker.sv
`timescale 1ns / 1ps

module line_follow_steering_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  lfs_pkg::req_word_type         req_word,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  lfs_pkg::rsp_word_type         rsp_word,
   input  logic                          csr_write_en,
   input  logic [lfs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lfs_pkg::CSR_W-1:0]     csr_data,
   output int                            pending,
   output int                            failures,
   output int                            checked
);

   import lfs_pkg::*;

   cfg_type                 steer_cfg;
   logic signed [ERR_W-1:0] last_error;
   rsp_word_type            expected_drive [$];

   // Direction comes from the sign of the speed; duty is its magnitude clipped to 255.
   function automatic logic [8:0] motor_cmd(input longint speed);
      longint mag;
      mag = (speed < 0) ? -speed : speed;
      if (mag > 255) mag = 255;
      return {speed > 0, mag[7:0]};
   endfunction

   function automatic bit predict_drive(input req_word_type w, output rsp_word_type drive);
      longint base, sharp, smooth, lvl, rvl, err, slope, sum, lspd, rspd;
      bit     emits;
      base   = steer_cfg.base_speed;
      sharp  = 160 * steer_cfg.sharp_gain;
      smooth = 70 * steer_cfg.smooth_gain;
      lvl    = w.left_level;
      rvl    = w.right_level;
      lspd   = base;
      rspd   = base;
      emits  = 1'b1;
      case (steer_cfg.mode)
         MODE_DIG3: begin
            case (w.line_bits)
               3'd1: begin lspd = base + sharp;  rspd = base - sharp;  end
               3'd3: begin lspd = base + smooth; rspd = base - smooth; end
               3'd4: begin lspd = base - sharp;  rspd = base + sharp;  end
               3'd5: emits = 1'b0;
               3'd6: begin lspd = base - smooth; rspd = base + smooth; end
               default: ;
            endcase
         end
         MODE_DIG2: begin
            case (w.line_bits[1:0])
               2'd1: begin lspd = base + sharp; rspd = base - sharp; end
               2'd2: begin lspd = base - sharp; rspd = base + sharp; end
               default: ;
            endcase
         end
         MODE_PD: begin
            err   = lvl - rvl;
            slope = err - last_error;
            sum   = $signed(steer_cfg.prop_gain) * err + $signed(steer_cfg.deriv_gain) * slope;
            lspd  = (base * 256 + sum) / 256;
            rspd  = (base * 256 - sum) / 256;
            last_error = err[ERR_W-1:0];
         end
         default: begin
            if (lvl == 0) begin
               emits = 1'b0;
            end else if (lvl <= 400) begin
               lspd = base - 100;
               rspd = base + 100;
            end else if (lvl >= 800) begin
               lspd = base + 100;
               rspd = base - 100;
            end
         end
      endcase
      drive = {motor_cmd(lspd), motor_cmd(rspd)};
      return emits;
   endfunction

   always @(posedge clock) begin
      rsp_word_type want;
      rsp_word_type drive;
      if (reset) begin
         steer_cfg  = '{MODE_DIG3, 8'd120, 4'd1, 4'd1, 16'sd0, 16'sd0};
         last_error = '0;
         failures   = 0;
         checked    = 0;
         expected_drive.delete();
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_MODE:        steer_cfg.mode        = mode_type'(csr_data[1:0]);
               CSR_BASE_SPEED:  steer_cfg.base_speed  = csr_data[7:0];
               CSR_SHARP_GAIN:  steer_cfg.sharp_gain  = csr_data[3:0];
               CSR_SMOOTH_GAIN: steer_cfg.smooth_gain = csr_data[3:0];
               CSR_PROP_GAIN:   steer_cfg.prop_gain   = csr_data;
               CSR_DERIV_GAIN:  steer_cfg.deriv_gain  = csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            if (predict_drive(req_word, drive)) expected_drive.push_back(drive);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_drive.size() == 0) begin
               failures++;
               if (failures <= 10) begin
                  $display("Drive word %h arrived with nothing predicted.", rsp_word);
               end
            end else begin
               want = expected_drive.pop_front();
               checked++;
               if (want.left_forward !== rsp_word.left_forward ||
                   want.left_duty !== rsp_word.left_duty ||
                   want.right_forward !== rsp_word.right_forward ||
                   want.right_duty !== rsp_word.right_duty) begin
                  failures++;
                  if (failures <= 10) begin
                     $display("Drive word %0d: expected L %b/%0d R %b/%0d, got L %b/%0d R %b/%0d",
                              checked, want.left_forward, want.left_duty,
                              want.right_forward, want.right_duty,
                              rsp_word.left_forward, rsp_word.left_duty,
                              rsp_word.right_forward, rsp_word.right_duty);
                  end
               end
            end
         end
      end
      pending = expected_drive.size();
   end

endmodule

>>> test/tb_line_follow_steering_core.sv
`timescale 1ns / 1ps

module tb_line_follow_steering_core;

   import lfs_pkg::*;

   localparam int HOLD_CYCLES = 300;
   localparam int QUIET_LIMIT = 3000;
   localparam int PHASES      = 12;
   localparam int PHASE_WORDS = 70;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   req_word_type         req_word;
   logic                 rsp_valid;
   logic                 rsp_stall;
   rsp_word_type         rsp_word;
   logic                 csr_write_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_data;

   int pending;
   int failures;
   int checked;
   int send_idle_pct = 0;
   int stall_pct     = 0;
   bit hold_req      = 1'b0;
   int words_sent    = 0;
   int settings_done = 0;
   int quiet_cycles  = 0;

   line_follow_steering_core u_top (
      .clock, .reset, .req_valid, .req_stall, .req_word,
      .rsp_valid, .rsp_stall, .rsp_word, .csr_write_en, .csr_index, .csr_data
   );

   line_follow_steering_checker u_checker (
      .clock, .reset, .req_valid, .req_stall, .req_word,
      .rsp_valid, .rsp_stall, .rsp_word, .csr_write_en, .csr_index, .csr_data,
      .pending, .failures, .checked
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("No word moved for %0d cycles.", QUIET_LIMIT);
            $display("tb_line_follow_steering_core: FAIL");
            $finish;
         end
      end
   end

   // The receiver normally stalls at random; on request it holds off for a long stretch.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   function automatic logic [LEVEL_W-1:0] random_level();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         2: return LEVEL_W'(399 + $urandom_range(3));
         3: return LEVEL_W'(798 + $urandom_range(3));
         default: return LEVEL_W'($urandom);
      endcase
   endfunction

   function automatic logic [GAIN_W-1:0] random_gain();
      logic signed [8:0] modest;
      modest = 9'($urandom);
      if ($urandom_range(3) == 0) return GAIN_W'($urandom);
      return GAIN_W'(modest);
   endfunction

   task automatic send_word(input logic [2:0] bits, input logic [LEVEL_W-1:0] left, right);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= '{bits, left, right};
      do @(posedge clock); while (req_stall);
      words_sent++;
      @(negedge clock);
   endtask

   // Words that yield no result may still be in the pipeline, so wait out the latency too.
   task automatic settle();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   task automatic program_regs(input cfg_type setting);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_MODE;
      csr_data     <= CSR_W'(setting.mode);
      @(negedge clock);
      csr_index    <= CSR_BASE_SPEED;
      csr_data     <= CSR_W'(setting.base_speed);
      @(negedge clock);
      csr_index    <= CSR_SHARP_GAIN;
      csr_data     <= CSR_W'(setting.sharp_gain);
      @(negedge clock);
      csr_index    <= CSR_SMOOTH_GAIN;
      csr_data     <= CSR_W'(setting.smooth_gain);
      @(negedge clock);
      csr_index    <= CSR_PROP_GAIN;
      csr_data     <= setting.prop_gain;
      @(negedge clock);
      csr_index    <= CSR_DERIV_GAIN;
      csr_data     <= setting.deriv_gain;
      @(negedge clock);
      csr_write_en <= 1'b0;
      settings_done++;
   endtask

   initial begin
      cfg_type setting;
      int      phase;
      int      n;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_word     = '0;
      csr_write_en = 1'b0;
      csr_index    = CSR_MODE;
      csr_data     = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Every three-sensor pattern under the reset settings.
      for (n = 0; n < 8; n++) begin
         send_word(3'(n), {LEVEL_W{n[0]}}, {LEVEL_W{n[1]}});
      end
      settle();

      // Two-sensor mode with the left bit set on half the patterns, which must be ignored.
      setting = '{MODE_DIG2, 8'd255, 4'd15, 4'd0, 16'sd0, 16'sd0};
      program_regs(setting);
      send_word(3'd4, random_level(), random_level());
      send_word(3'd1, random_level(), random_level());
      send_word(3'd6, random_level(), random_level());
      send_word(3'd3, random_level(), random_level());
      settle();

      // One-sensor mode across the band edges, with a zero sample that yields nothing.
      setting = '{MODE_ONE, 8'd0, 4'd0, 4'd15, 16'sd0, 16'sd0};
      program_regs(setting);
      send_word(3'd0, 10'd0, 10'd0);
      send_word(3'd7, 10'd1, 10'd1023);
      send_word(3'd0, 10'd400, 10'd0);
      send_word(3'd7, 10'd401, 10'd1023);
      send_word(3'd0, 10'd799, 10'd0);
      send_word(3'd7, 10'd800, 10'd1023);
      send_word(3'd0, 10'd1023, 10'd0);
      settle();

      // PD mode with the strongest gains and the largest error swing.
      setting = '{MODE_PD, 8'd255, 4'd0, 4'd0, 16'h8000, 16'h7FFF};
      program_regs(setting);
      send_word(3'd0, 10'd1023, 10'd0);
      send_word(3'd0, 10'd0, 10'd1023);
      send_word(3'd7, 10'd512, 10'd512);
      send_word(3'd7, 10'd0, 10'd0);

      for (phase = 0; phase < PHASES; phase++) begin
         settle();
         setting.mode = mode_type'(phase % 4);
         if (phase < 6 && phase % 2 == 0) begin
            setting.base_speed  = '0;
            setting.sharp_gain  = '0;
            setting.smooth_gain = '0;
            setting.prop_gain   = 16'h8000;
            setting.deriv_gain  = 16'h8000;
         end else if (phase < 6) begin
            setting.base_speed  = '1;
            setting.sharp_gain  = '1;
            setting.smooth_gain = '1;
            setting.prop_gain   = 16'h7FFF;
            setting.deriv_gain  = 16'h7FFF;
         end else begin
            setting.base_speed  = 8'($urandom);
            setting.sharp_gain  = 4'($urandom);
            setting.smooth_gain = 4'($urandom);
            setting.prop_gain   = random_gain();
            setting.deriv_gain  = random_gain();
         end
         program_regs(setting);
         case ((phase + phase / 4) % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 86; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 86; end
            default: begin send_idle_pct = 35; stall_pct = 35; end
         endcase
         if (phase == 8) hold_req = 1'b1;
         for (n = 0; n < PHASE_WORDS; n++) begin
            send_word(3'($urandom), random_level(), random_level());
         end
      end
      settle();

      $display("Drove %0d sensor words under %0d register settings covering all four modes,",
               words_sent, settings_done);
      $display("with idle, stall and long hold-off phases; %0d drive words checked, %0d failures.",
               checked, failures);
      if (failures == 0 && pending == 0) begin
         $display("tb_line_follow_steering_core: PASS");
      end else begin
         $display("tb_line_follow_steering_core: FAIL");
      end
      $finish;
   end

endmodule
